### rtl/eaut_pkg.sv
// Shared constants, widths and types of the encoder angle unwrap tracker.
package eaut_pkg;

  localparam int ANGLE_BITS       = 14;
  localparam int FILTER_FRAC_BITS = 8;
  localparam int ACCUM_WIDTH      = 32;

  localparam int RATE_W   = 16;
  localparam int ALPHA_W  = 9;
  localparam int ALPHA_FRAC = 8;
  localparam int VEL_W    = ANGLE_BITS + RATE_W;
  localparam int FILT_W   = ANGLE_BITS + FILTER_FRAC_BITS;
  localparam int DELTA_W  = ANGLE_BITS + 1;

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(1000);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(51);

  // Register word indexes on the configuration port.
  localparam logic REG_SAMPLE_RATE  = 1'b0;
  localparam logic REG_FILTER_ALPHA = 1'b1;

  // Input item kinds.
  localparam logic KIND_SAMPLE   = 1'b0;
  localparam logic KIND_SET_ZERO = 1'b1;

  localparam int IN_DATA_W  = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ANGLE_BITS + ACCUM_WIDTH + VEL_W + FILT_W
                              + ANGLE_BITS + ACCUM_WIDTH;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [RATE_W-1:0]  sample_rate_hz;
    logic [ALPHA_W-1:0] filter_alpha_q8;
  } cfg_t;

  typedef struct packed {
    logic                          first_sample;
    logic [ANGLE_BITS-1:0]         absolute_angle;
    logic signed [ACCUM_WIDTH-1:0] unwrapped_angle;
    logic signed [VEL_W-1:0]       velocity;
    logic [FILT_W-1:0]             filtered_angle;
    logic [ANGLE_BITS-1:0]         rel_angle;
    logic signed [ACCUM_WIDTH-1:0] rel_unwrapped;
  } result_t;

endpackage

### rtl/eaut_cfg.sv
// Configuration registers of the tracker behind an APB-style port.
module eaut_cfg
  import eaut_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [RATE_W-1:0]  sample_rate_hz;
  logic [ALPHA_W-1:0] filter_alpha_q8;
  logic               wr_en;
  logic               word_sel;

  assign pready   = 1'b1;
  assign word_sel = paddr[2];
  assign wr_en    = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz  <= RATE_RESET;
      filter_alpha_q8 <= ALPHA_RESET;
    end else if (wr_en) begin
      unique case (word_sel)
        REG_SAMPLE_RATE:  sample_rate_hz  <= pwdata[RATE_W-1:0];
        REG_FILTER_ALPHA: filter_alpha_q8 <= pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (word_sel)
      REG_SAMPLE_RATE:  prdata = {{(32-RATE_W){1'b0}}, sample_rate_hz};
      REG_FILTER_ALPHA: prdata = {{(32-ALPHA_W){1'b0}}, filter_alpha_q8};
      default:          prdata = '0;
    endcase
  end

  assign cfg.sample_rate_hz  = sample_rate_hz;
  assign cfg.filter_alpha_q8 = filter_alpha_q8;

endmodule

### rtl/eaut_core.sv
// Tracker state and the single-pass update that forms one result per item.
module eaut_core
  import eaut_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  kind,
  input  logic [ANGLE_BITS-1:0] raw_angle,
  input  cfg_t                  cfg,
  output result_t               result
);

  localparam int WIDE_W = ANGLE_BITS + 2;
  localparam int PROD_W = ALPHA_W + FILT_W;
  localparam int SUM_W  = ACCUM_WIDTH + 1;
  localparam logic signed [WIDE_W-1:0] TURN = WIDE_W'(1) <<< ANGLE_BITS;
  localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) <<< (ANGLE_BITS - 1);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    SUM_W'({1'b0, {(ACCUM_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

  function automatic logic signed [ACCUM_WIDTH-1:0] sat_acc(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [ACCUM_WIDTH-1:0] r;
    if (v > ACC_MAX)      r = ACC_MAX[ACCUM_WIDTH-1:0];
    else if (v < ACC_MIN) r = ACC_MIN[ACCUM_WIDTH-1:0];
    else                  r = v[ACCUM_WIDTH-1:0];
    return r;
  endfunction

  logic                          seen_first, seen_first_next;
  logic [ANGLE_BITS-1:0]         last_angle, last_angle_next;
  logic signed [ACCUM_WIDTH-1:0] unwrapped_total, unwrapped_total_next;
  logic [FILT_W-1:0]             smoothed_angle, smoothed_angle_next;
  logic [ANGLE_BITS-1:0]         zero_reference, zero_reference_next;
  logic signed [VEL_W-1:0]       last_velocity, last_velocity_next;

  logic signed [WIDE_W-1:0]  diff;
  logic signed [WIDE_W-1:0]  diff_wrap;
  logic signed [DELTA_W-1:0] delta;
  logic signed [VEL_W+1:0]   vel_prod;
  logic [ALPHA_W-1:0]        alpha;
  logic [PROD_W-1:0]         prod_new;
  logic [PROD_W-1:0]         prod_old;
  logic [PROD_W:0]           filt_acc;
  logic signed [SUM_W-1:0]   unw_sum;
  logic signed [SUM_W-1:0]   rel_sum;
  logic                      first_flag;

  // Wrap-aware step; exactly half a turn keeps its sign.
  always_comb begin
    diff = $signed({2'b00, raw_angle}) - $signed({2'b00, last_angle});
    if (diff > HALF)       diff_wrap = diff - TURN;
    else if (diff < -HALF) diff_wrap = diff + TURN;
    else                   diff_wrap = diff;
    delta = diff_wrap[DELTA_W-1:0];
  end

  assign vel_prod = (VEL_W+2)'(delta) * (VEL_W+2)'($signed({1'b0, cfg.sample_rate_hz}));
  assign unw_sum  = SUM_W'(unwrapped_total) + SUM_W'(delta);

  assign alpha    = (cfg.filter_alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha_q8;
  assign prod_new = PROD_W'(alpha) * PROD_W'({raw_angle, {FILTER_FRAC_BITS{1'b0}}});
  assign prod_old = PROD_W'(ALPHA_ONE - alpha) * PROD_W'(smoothed_angle);
  assign filt_acc = (PROD_W+1)'(prod_new) + (PROD_W+1)'(prod_old)
                  + (PROD_W+1)'(ALPHA_ONE >> 1);

  always_comb begin
    seen_first_next      = seen_first;
    last_angle_next      = last_angle;
    unwrapped_total_next = unwrapped_total;
    smoothed_angle_next  = smoothed_angle;
    zero_reference_next  = zero_reference;
    last_velocity_next   = last_velocity;
    first_flag           = 1'b0;
    if (kind == KIND_SET_ZERO) begin
      zero_reference_next = last_angle;
    end else if (!seen_first) begin
      seen_first_next      = 1'b1;
      last_angle_next      = raw_angle;
      unwrapped_total_next = ACCUM_WIDTH'(raw_angle);
      smoothed_angle_next  = {raw_angle, {FILTER_FRAC_BITS{1'b0}}};
      last_velocity_next   = '0;
      first_flag           = 1'b1;
    end else begin
      last_angle_next      = raw_angle;
      unwrapped_total_next = sat_acc(unw_sum);
      last_velocity_next   = vel_prod[VEL_W-1:0];
      smoothed_angle_next  = filt_acc[ALPHA_FRAC +: FILT_W];
    end
  end

  assign rel_sum = SUM_W'(unwrapped_total_next)
                 - SUM_W'($signed({1'b0, zero_reference_next}));

  assign result.first_sample    = first_flag;
  assign result.absolute_angle  = last_angle_next;
  assign result.unwrapped_angle = unwrapped_total_next;
  assign result.velocity        = last_velocity_next;
  assign result.filtered_angle  = smoothed_angle_next;
  assign result.rel_angle       = last_angle_next - zero_reference_next;
  assign result.rel_unwrapped   = sat_acc(rel_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first      <= 1'b0;
      last_angle      <= '0;
      unwrapped_total <= '0;
      smoothed_angle  <= '0;
      zero_reference  <= '0;
      last_velocity   <= '0;
    end else if (fire) begin
      seen_first      <= seen_first_next;
      last_angle      <= last_angle_next;
      unwrapped_total <= unwrapped_total_next;
      smoothed_angle  <= smoothed_angle_next;
      zero_reference  <= zero_reference_next;
      last_velocity   <= last_velocity_next;
    end
  end

endmodule

### rtl/encoder_angle_unwrap_tracker.sv
// Top level: stream ports, input register, tracker core and result register.
// An item goes from the input register through the core into the result
// register. Throughput: one item per cycle while m_tready allows; the core
// updates its state in a single pass between the input and result registers.
// Reset (rst, synchronous): clears the tracker state, empties both registers,
// and loads sample_rate_hz = 1000 and filter_alpha_q8 = 51.
module encoder_angle_unwrap_tracker
  import eaut_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // raw_angle, then zero fill
  input  logic                  s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // absolute_angle, unwrapped_angle, velocity, filtered_angle,
  // rel_angle, rel_unwrapped
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,   // first_sample
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t                  cfg;
  result_t               result;
  logic                  in_valid;
  logic                  in_kind;
  logic [ANGLE_BITS-1:0] in_raw;
  logic                  fire;
  result_t               out_res;

  eaut_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The core consumes the held item whenever the result register is free
  // or is being emptied in the same cycle.
  assign fire     = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_raw  <= s_tdata[ANGLE_BITS-1:0];
    end
  end

  eaut_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .kind      (in_kind),
    .raw_angle (in_raw),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= result;
    end
  end

  assign m_tuser = out_res.first_sample;
  assign m_tdata = OUT_DATA_W'({out_res.rel_unwrapped,
                               out_res.rel_angle,
                               out_res.filtered_angle,
                               out_res.velocity,
                               out_res.unwrapped_angle,
                               out_res.absolute_angle});

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("result register not loaded after the core consumed an item");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_raw) && $stable(in_kind))
    else $error("input register lost a waiting item");

  a_seed_velocity_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> out_res.velocity == '0)
    else $error("seeding result carries nonzero velocity");

  a_relative_consistent: assert property (@(posedge clk) disable iff (rst)
    fire && in_kind == KIND_SET_ZERO |=> out_res.rel_angle == '0)
    else $error("set zero result has nonzero relative angle");

endmodule

### bench/encoder_angle_unwrap_tracker_tb.sv
// Self-checking testbench for the encoder angle unwrap tracker with a scoreboard class.
module encoder_angle_unwrap_tracker_tb;
  import eaut_pkg::*;

  localparam int     TURN         = 1 << ANGLE_BITS;
  localparam int     HALF_TURN    = TURN / 2;
  localparam int     ALPHA_ONE    = 1 << ALPHA_FRAC;
  localparam longint ACC_MAX      = (longint'(1) << (ACCUM_WIDTH - 1)) - 1;
  localparam longint ACC_MIN      = -ACC_MAX - 1;

  // Tracks the tracker state, predicts one result per accepted input transfer
  // and compares results in order.
  class unwrap_scoreboard;
    logic [RATE_W-1:0]     rate_hz;
    logic [ALPHA_W-1:0]    alpha_q8;
    bit                    seeded;
    logic [ANGLE_BITS-1:0] last_angle;
    longint                total;
    logic [FILT_W-1:0]     smoothed;
    logic [ANGLE_BITS-1:0] zero_ref;
    longint                velocity;
    result_t               pending_results[$];
    int                    mismatches;

    function new();
      rate_hz    = RATE_RESET;
      alpha_q8   = ALPHA_RESET;
      seeded     = 1'b0;
      last_angle = '0;
      total      = 0;
      smoothed   = '0;
      zero_ref   = '0;
      velocity   = 0;
      mismatches = 0;
    endfunction

    function longint clamp_accum(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_SAMPLE_RATE) rate_hz = value[RATE_W-1:0];
      else alpha_q8 = value[ALPHA_W-1:0];
    endfunction

    function void note_input(logic kind, logic [ANGLE_BITS-1:0] raw);
      longint          delta;
      longint          rel;
      longint unsigned acc;
      int unsigned     a;
      bit              first;
      result_t         want;
      first = 1'b0;
      if (kind == KIND_SET_ZERO) begin
        zero_ref = last_angle;
      end else if (!seeded) begin
        seeded     = 1'b1;
        first      = 1'b1;
        last_angle = raw;
        total      = clamp_accum(longint'(raw));
        smoothed   = FILT_W'(raw) << FILTER_FRAC_BITS;
        velocity   = 0;
      end else begin
        // Shortest way round; exactly half a turn keeps the sign it came with.
        delta = longint'(raw) - longint'(last_angle);
        if (delta > HALF_TURN) delta -= TURN;
        if (delta < -HALF_TURN) delta += TURN;
        total    = clamp_accum(total + delta);
        velocity = delta * longint'(rate_hz);
        a        = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
        acc      = longint'(a) * (longint'(raw) << FILTER_FRAC_BITS)
                 + longint'(ALPHA_ONE - a) * longint'(smoothed)
                 + longint'(ALPHA_ONE / 2);
        smoothed   = FILT_W'(acc >> ALPHA_FRAC);
        last_angle = raw;
      end
      rel = clamp_accum(total - longint'(zero_ref));
      want.first_sample    = first;
      want.absolute_angle  = last_angle;
      want.unwrapped_angle = total[ACCUM_WIDTH-1:0];
      want.velocity        = velocity[VEL_W-1:0];
      want.filtered_angle  = smoothed;
      want.rel_angle       = last_angle - zero_ref;
      want.rel_unwrapped   = rel[ACCUM_WIDTH-1:0];
      pending_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic first, logic [OUT_DATA_W-1:0] data);
      result_t want, got;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer expected none, actual %0h", $time, data);
        return;
      end
      want = pending_results.pop_front();
      got.first_sample = first;
      {got.rel_unwrapped, got.rel_angle, got.filtered_angle, got.velocity,
       got.unwrapped_angle, got.absolute_angle} = data[OUT_FIELDS_W-1:0];
      compare_field("first_sample", want.first_sample, got.first_sample);
      compare_field("absolute_angle", want.absolute_angle, got.absolute_angle);
      compare_field("unwrapped_angle", want.unwrapped_angle, got.unwrapped_angle);
      compare_field("velocity", want.velocity, got.velocity);
      compare_field("filtered_angle", want.filtered_angle, got.filtered_angle);
      compare_field("rel_angle", want.rel_angle, got.rel_angle);
      compare_field("rel_unwrapped", want.rel_unwrapped, got.rel_unwrapped);
    endfunction
  endclass

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;     // raw_angle, then zero fill
  logic                  s_tuser  = 1'b0;   // kind
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // absolute_angle, unwrapped_angle, velocity, filtered_angle,
  // rel_angle, rel_unwrapped
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;           // first_sample
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [2:0]            paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;

  unwrap_scoreboard sb = new();

  encoder_angle_unwrap_tracker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Result side: while snk_idle is set, stall for a random number of cycles before each transfer.
  initial begin : result_sink
    int stall;
    forever begin
      stall = snk_idle ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // tvalid is left high after a transfer so back-to-back items need no toggle.
  task automatic send_item(input logic kind, input logic [ANGLE_BITS-1:0] raw);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(raw);
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    sb.note_input(kind, raw);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          phase, n, r;
    logic [31:0] rate, alpha;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero reference before any sample, seeding, wrap both ways,
    // exact half turns and a delta just past half a turn.
    send_item(KIND_SET_ZERO, 14'h3FFF);
    send_item(KIND_SAMPLE, 14'd16383);
    send_item(KIND_SAMPLE, 14'd0);
    send_item(KIND_SAMPLE, 14'd8192);
    send_item(KIND_SAMPLE, 14'd0);
    send_item(KIND_SAMPLE, 14'd8193);
    send_item(KIND_SET_ZERO, 14'd0);
    send_item(KIND_SAMPLE, 14'd5);
    send_item(KIND_SAMPLE, 14'd16383);

    // Largest rate with half-turn steps gives both velocity extremes.
    wait_drain();
    write_reg(REG_SAMPLE_RATE, 32'd65535);
    write_reg(REG_FILTER_ALPHA, 32'd256);
    send_item(KIND_SAMPLE, 14'd8191);
    send_item(KIND_SAMPLE, 14'd16383);
    send_item(KIND_SET_ZERO, 14'd0);
    send_item(KIND_SAMPLE, 14'd0);

    // Zero rate and a filter that holds its value.
    wait_drain();
    write_reg(REG_SAMPLE_RATE, 32'd0);
    write_reg(REG_FILTER_ALPHA, 32'd0);
    send_item(KIND_SAMPLE, 14'd12000);
    send_item(KIND_SAMPLE, 14'd3);

    // Alpha above one is clamped.
    wait_drain();
    write_reg(REG_SAMPLE_RATE, 32'd1);
    write_reg(REG_FILTER_ALPHA, 32'd511);
    send_item(KIND_SAMPLE, 14'd4000);
    send_item(KIND_SAMPLE, 14'd0);

    for (phase = 0; phase < 4; phase++) begin
      wait_drain();
      case ($urandom_range(0, 4))
        0:       rate = 0;
        1:       rate = 65535;
        default: rate = $urandom_range(0, 65535);
      endcase
      alpha = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511)
                                          : $urandom_range(0, ALPHA_ONE);
      write_reg(REG_SAMPLE_RATE, rate);
      write_reg(REG_FILTER_ALPHA, alpha);
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      for (n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        if (r < 6)
          send_item(KIND_SET_ZERO, ANGLE_BITS'($urandom_range(0, TURN - 1)));
        else if (r < 55)
          send_item(KIND_SAMPLE,
                    ANGLE_BITS'(sb.last_angle + $urandom_range(0, 128) - 64));
        else if (r < 70)
          send_item(KIND_SAMPLE,
                    ANGLE_BITS'(sb.last_angle + HALF_TURN + $urandom_range(0, 4) - 2));
        else
          send_item(KIND_SAMPLE, ANGLE_BITS'($urandom_range(0, TURN - 1)));
        if ($urandom_range(0, 49) == 0) wait_drain();
      end
    end

    // A short full-rate run with large steps both ways.
    wait_drain();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    for (n = 0; n < 24; n++)
      send_item(KIND_SAMPLE,
                ANGLE_BITS'(sb.last_angle + $urandom_range(0, TURN - 1) - HALF_TURN));

    s_tvalid <= 1'b0;
    for (n = 0; n < 1000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results expected, actual none", $time, sb.pending());
      sb.mismatches += sb.pending();
    end
    if (sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
